### rtl/core/signed_decimal_ascii_defines.svh
// ----------------------------------------------------------------------------
// Signed decimal ASCII assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication
`define SDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sda_pkg.sv
// ----------------------------------------------------------------------------
// Signed decimal ASCII package
// Payload types, chain control codes and character constants.
// ----------------------------------------------------------------------------
package sda_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned DIGITS  = 20;

  // ASCII codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [3:0] CH_DIGIT_HI = 4'h3;  // '0'..'9' are 0x30..0x39

  // Configuration register indexes
  localparam logic [1:0] REG_ZERO_FILL   = 2'd0;
  localparam logic [1:0] REG_FIELD_WIDTH = 2'd1;
  localparam logic [1:0] REG_CAPACITY    = 2'd2;

  // Digit chain operation, common to all cells
  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_CLEAR,
    MODE_DABBLE,
    MODE_SHIFT
  } sda_mode_e;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_signed;
  } sda_in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       no_room;
  } sda_out_t;

endpackage

### rtl/core/sda_cell.sv
// ----------------------------------------------------------------------------
// Signed decimal ASCII digit cell
// One BCD digit: hold, clear, add-3 / shift step for binary to BCD, or digit shift up.
// ----------------------------------------------------------------------------
module sda_cell (
  input  logic               clk_i,
  input  sda_pkg::sda_mode_e mode_i,
  input  logic               bit_i,    // carry bit from lower cell
  input  logic [3:0]         digit_i,  // digit of lower cell
  output logic [3:0]         digit_o,
  output logic               bit_o
);
  import sda_pkg::*;

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  // Correct digits of five and up before the doubling
  assign adj = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;

  always_comb begin
    unique case (mode_i)
      MODE_HOLD:   digit_d = digit_q;
      MODE_CLEAR:  digit_d = 4'd0;
      MODE_DABBLE: digit_d = {adj[2:0], bit_i};
      MODE_SHIFT:  digit_d = digit_i;
      default:     digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;
  assign bit_o   = adj[3];

endmodule

### rtl/core/sda_chain.sv
// ----------------------------------------------------------------------------
// Signed decimal ASCII digit chain
// Row of BCD cells, least significant at the bottom; the top digit is read.
// ----------------------------------------------------------------------------
module sda_chain (
  input  logic               clk_i,
  input  sda_pkg::sda_mode_e mode_i,
  input  logic               bit_i,   // next binary bit, msb first
  output logic [3:0]         top_o,   // most significant digit
  output logic               ovf_o    // carry out of the top cell
);
  import sda_pkg::*;

  logic [3:0] digit [DIGITS];
  logic       carry [DIGITS];

  for (genvar k = 0; k < DIGITS; k++) begin : g_cell
    logic       bit_in;
    logic [3:0] digit_in;

    if (k == 0) begin : g_first
      assign bit_in   = bit_i;
      assign digit_in = 4'd0;
    end else begin : g_next
      assign bit_in   = carry[k-1];
      assign digit_in = digit[k-1];
    end

    sda_cell u_cell (
      .clk_i   (clk_i),
      .mode_i  (mode_i),
      .bit_i   (bit_in),
      .digit_i (digit_in),
      .digit_o (digit[k]),
      .bit_o   (carry[k])
    );
  end

  assign top_o = digit[DIGITS-1];
  assign ovf_o = carry[DIGITS-1];

endmodule

### rtl/core/signed_decimal_ascii.sv
// ----------------------------------------------------------------------------
// Signed decimal ASCII converter
// 64-bit value to decimal text, one character per output item.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carries a value and a signed flag.
// Output channel: out_valid_o / out_stall_i carries one character per item,
// last set on the final one; a value that does not fit the capacity gives
// one item with no_room set, character zero and last set.
// Config port: cfg_we_i writes cfg_data_i to register cfg_index_i
// (0 zero-fill digit count, 1 field_width, 2 capacity); others are ignored.
// Sequence: an accepted value runs through the BCD cell chain
// (one binary bit per cycle), then leading zeros are dropped down to the
// digits kept and the top digit is found, the text is sized, then one
// character per cycle enters the output register while the receiver
// takes it.
// One value is in work at a time; the next is accepted once the last
// character is registered.
// Stall on the output holds the registered item and pauses emission.
// Reset empties the output register, returns to idle and sets
// zero_fill 0, field_width 0, capacity 32.
// ----------------------------------------------------------------------------
`include "signed_decimal_ascii_defines.svh"

module signed_decimal_ascii (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sda_pkg::sda_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sda_pkg::sda_out_t  out_data_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i
);
  import sda_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_SIZE,
    ST_EMIT
  } state_e;

  // Configuration registers
  logic [4:0] zero_fill_q;
  logic [5:0] field_width_q;
  logic [6:0] capacity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_fill_q   <= 5'd0;
      field_width_q <= 6'd0;
      capacity_q    <= 7'd32;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ZERO_FILL:   zero_fill_q   <= cfg_data_i[4:0];
        REG_FIELD_WIDTH: field_width_q <= cfg_data_i[5:0];
        REG_CAPACITY:    capacity_q    <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  state_e          state_q, state_d;
  logic [5:0]      cyc_q, cyc_d;      // conversion bit count
  logic [4:0]      cnt_q, cnt_d;      // digits still in the text
  logic [5:0]      pad_q, pad_d;      // spaces still to send
  logic            sign_q, sign_d;    // minus still to send
  logic [6:0]      rem_q, rem_d;      // characters still to send
  logic            noroom_q, noroom_d;
  logic            out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] mag_q, mag_d;
  sda_out_t        out_q, out_d;

  logic            in_fire, can_load, norm_shift;
  logic [4:0]      min_cap, len;
  logic [5:0]      pad_calc;
  logic [6:0]      total, limit;
  logic [3:0]      top_digit;
  logic            chain_ovf;
  sda_mode_e       mode;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign can_load   = !out_valid_q || !out_stall_i;

  // Digit count floor: at least one digit, at most the chain length
  assign min_cap = (zero_fill_q > 5'(DIGITS)) ? 5'(DIGITS) :
                   (zero_fill_q == 5'd0)      ? 5'd1 : zero_fill_q;
  assign norm_shift = (cnt_q > min_cap) && (top_digit == 4'd0);

  // Text sizing
  assign len      = cnt_q + {4'd0, sign_q};
  assign pad_calc = (field_width_q > {1'b0, len}) ? (field_width_q - {1'b0, len}) : 6'd0;
  assign total    = {1'b0, pad_calc} + {2'd0, len};
  assign limit    = (capacity_q > 7'd64) ? 7'd64 : capacity_q;

  // Chain operation per state
  always_comb begin
    unique case (state_q)
      ST_IDLE: mode = in_fire ? MODE_CLEAR : MODE_HOLD;
      ST_CONV: mode = MODE_DABBLE;
      ST_NORM: mode = norm_shift ? MODE_SHIFT : MODE_HOLD;
      ST_SIZE: mode = MODE_HOLD;
      ST_EMIT: mode = (can_load && !noroom_q && (pad_q == 6'd0) && !sign_q) ?
                      MODE_SHIFT : MODE_HOLD;
      default: mode = MODE_HOLD;
    endcase
  end

  sda_chain u_chain (
    .clk_i  (clk_i),
    .mode_i (mode),
    .bit_i  (mag_q[VALUE_W-1]),
    .top_o  (top_digit),
    .ovf_o  (chain_ovf)
  );

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    cyc_d       = cyc_q;
    cnt_d       = cnt_q;
    pad_d       = pad_q;
    sign_d      = sign_q;
    rem_d       = rem_q;
    noroom_d    = noroom_q;
    mag_d       = mag_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          sign_d  = in_data_i.is_signed && in_data_i.value[VALUE_W-1];
          mag_d   = sign_d ? (~in_data_i.value + 64'd1) : in_data_i.value;
          cyc_d   = 6'd0;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        mag_d = {mag_q[VALUE_W-2:0], 1'b0};
        cyc_d = cyc_q + 6'd1;
        if (cyc_q == 6'(VALUE_W - 1)) begin
          cnt_d   = 5'(DIGITS);
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (norm_shift) begin
          cnt_d = cnt_q - 5'd1;
        end else begin
          state_d = ST_SIZE;
        end
      end
      ST_SIZE: begin
        noroom_d = ({2'd0, len} >= capacity_q);
        pad_d    = pad_calc;
        rem_d    = (total > limit) ? limit : total;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          if (noroom_q) begin
            out_d   = '{character: CH_NUL, last: 1'b1, no_room: 1'b1};
            state_d = ST_IDLE;
          end else begin
            out_d.no_room = 1'b0;
            out_d.last    = (rem_q == 7'd1);
            rem_d         = rem_q - 7'd1;
            if (pad_q != 6'd0) begin
              out_d.character = CH_SPACE;
              pad_d           = pad_q - 6'd1;
            end else if (sign_q) begin
              out_d.character = CH_MINUS;
              sign_d          = 1'b0;
            end else begin
              out_d.character = {CH_DIGIT_HI, top_digit};
            end
            if (rem_q == 7'd1) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    cyc_q    <= cyc_d;
    cnt_q    <= cnt_d;
    pad_q    <= pad_d;
    sign_q   <= sign_d;
    rem_q    <= rem_d;
    noroom_q <= noroom_d;
    mag_q    <= mag_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `SDA_ASSERT_NOW(a_noroom_form, out_valid_o && out_data_o.no_room, out_data_o.last && (out_data_o.character == CH_NUL), "no-room item must be last with character zero")
  `SDA_ASSERT_NOW(a_no_overflow, state_q == ST_CONV, !chain_ovf, "BCD chain overflowed")
  `SDA_ASSERT_NOW(a_digit_range, (state_q == ST_NORM) || (state_q == ST_EMIT), top_digit <= 4'd9, "top digit is not decimal")
  `SDA_ASSERT_NEXT(a_busy_after_accept, in_fire, in_stall_o, "input taken while a value is in work")

endmodule

### tb/sv/signed_decimal_ascii_tb.sv
// ----------------------------------------------------------------------------
// Signed decimal ASCII converter testbench
// Feeds 64-bit values (signed and unsigned) through the converter under a
// sequence of zero_fill / field_width / capacity settings, predicts the
// emitted text one character at a time and compares every output item in
// order. Both channels idle at random; one long receiver hold-off backs
// the block up into its input.
// ----------------------------------------------------------------------------
module signed_decimal_ascii_tb;
  import sda_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;   // index the block must ignore
  localparam int MAX_EMIT  = 64;              // characters per value, at most
  localparam int LONG_HOLD = 600;             // receiver hold-off, in cycles
  localparam int REPORT_MAX = 10;

  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_LIGHT,
    PACE_TOGGLE,
    PACE_HEAVY
  } pace_e;

  // Predicts the text of each accepted value and checks characters in order
  class ascii_text_board;
    logic [4:0] zero_fill;
    logic [5:0] field_width;
    logic [6:0] capacity;
    sda_out_t   expected_chars[$];
    int         fail_count;

    function new();
      zero_fill   = '0;
      field_width = '0;
      capacity    = 7'd32;
      fail_count  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [6:0] data);
      case (idx)
        REG_ZERO_FILL:   zero_fill   = data[4:0];
        REG_FIELD_WIDTH: field_width = data[5:0];
        REG_CAPACITY:    capacity    = data;
        default: ;
      endcase
    endfunction

    // Expected characters for one accepted value
    function void note_value(sda_in_t item);
      logic        neg;
      logic [63:0] mag;
      logic [7:0]  rev [0:DIGITS];
      logic [7:0]  text [0:DIGITS+1];
      int          nd;
      int          len;
      int          pad;
      int          total;
      int          lim;
      sda_out_t    ch;
      neg = item.is_signed & item.value[63];
      mag = neg ? (~item.value + 64'd1) : item.value;
      // digits, least significant first; zero still gives one digit
      rev[0] = {CH_DIGIT_HI, 4'(mag % 64'd10)};
      mag = mag / 64'd10;
      nd = 1;
      while (mag != 0) begin
        rev[nd] = {CH_DIGIT_HI, 4'(mag % 64'd10)};
        mag = mag / 64'd10;
        nd++;
      end
      while (nd < int'(zero_fill) && nd < int'(DIGITS)) begin
        rev[nd] = {CH_DIGIT_HI, 4'd0};
        nd++;
      end
      len = 0;
      if (neg) begin
        text[0] = CH_MINUS;
        len = 1;
      end
      for (int i = nd - 1; i >= 0; i--) begin
        text[len] = rev[i];
        len++;
      end
      // text plus terminator must fit, else a single no-room item
      if (len >= int'(capacity)) begin
        ch.character = CH_NUL;
        ch.last      = 1'b1;
        ch.no_room   = 1'b1;
        expected_chars.push_back(ch);
        return;
      end
      pad   = (int'(field_width) > len) ? int'(field_width) - len : 0;
      total = pad + len;
      lim   = (int'(capacity) > MAX_EMIT) ? MAX_EMIT : int'(capacity);
      if (total > lim) total = lim;
      for (int i = 0; i < total; i++) begin
        ch.character = (i < pad) ? CH_SPACE : text[i-pad];
        ch.last      = (i == total - 1);
        ch.no_room   = 1'b0;
        expected_chars.push_back(ch);
      end
    endfunction

    function void mismatch(string why, sda_out_t want, sda_out_t got);
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("%s: expected char %h last %b no_room %b, got char %h last %b no_room %b",
                 why, want.character, want.last, want.no_room,
                 got.character, got.last, got.no_room);
    endfunction

    function void check_char(sda_out_t got);
      sda_out_t want;
      if (expected_chars.size() == 0) begin
        mismatch("character with nothing pending", 'x, got);
        return;
      end
      want = expected_chars.pop_front();
      if (got !== want) mismatch("character mismatch", want, got);
    endfunction

    function void close_out();
      if (expected_chars.size() != 0) begin
        fail_count += expected_chars.size();
        $display("%0d expected characters never arrived", expected_chars.size());
      end
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  sda_in_t    in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  sda_out_t   out_data_o;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_index_i = REG_ZERO_FILL;
  logic [6:0] cfg_data_i  = '0;

  ascii_text_board board = new();

  int    burst_left    = 0;
  pace_e pace          = PACE_FREE;
  int    pace_left     = 0;
  int    hold_left     = 0;
  bit    long_hold_req = 1'b0;

  signed_decimal_ascii dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic sda_in_t mk(logic [63:0] value, logic is_signed);
    sda_in_t item;
    item.value     = value;
    item.is_signed = is_signed;
    return item;
  endfunction

  function automatic logic [63:0] pow10(int k);
    logic [63:0] p;
    p = 64'd1;
    repeat (k) p = p * 64'd10;
    return p;
  endfunction

  // Random value: digit-count boundaries, extremes, small and wide magnitudes
  function automatic sda_in_t random_value();
    sda_in_t     item;
    logic [63:0] wide;
    wide           = {$urandom, $urandom};
    item.is_signed = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: item.value = 64'($urandom_range(0, 20));
      1: item.value = wide;
      2: item.value = pow10($urandom_range(0, 19)) + 64'($urandom_range(0, 2)) - 64'd1;
      3: begin
        item.value     = ~64'($urandom_range(0, 100000));
        item.is_signed = ($urandom_range(0, 3) != 0);
      end
      4: item.value = wide >> $urandom_range(0, 63);
      5: item.value = ~(wide >> $urandom_range(0, 63));
      6: begin
        case ($urandom_range(0, 3))
          0: item.value = '0;
          1: item.value = '1;
          2: item.value = 64'h8000_0000_0000_0000;
          default: item.value = 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
      end
      default: item.value = pow10($urandom_range(0, 18)) * 64'($urandom_range(1, 9)) +
                            64'(wide[15:0]);
    endcase
    return item;
  endfunction

  // Offer one value; bursts of back-to-back items separated by random gaps
  task automatic send_value(sda_in_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 160) : $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 8);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_value(item);
    burst_left--;
  endtask

  // Let every pending character come out so the block is idle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.expected_chars.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [6:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    board.write_reg(idx, data);
  endtask

  // Unused upper data bits are randomized; the block must mask them
  task automatic set_config(logic [4:0] md, logic [5:0] fw, logic [6:0] cap,
                            bit poke_unused);
    cfg_write(REG_ZERO_FILL, {2'($urandom), md});
    cfg_write(REG_FIELD_WIDTH, {1'($urandom), fw});
    cfg_write(REG_CAPACITY, cap);
    if (poke_unused) cfg_write(REG_UNUSED, 7'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Receiver: consume and check, stalling on changing patterns
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_char(out_data_o);
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (pace_left == 0) begin
          pace      = pace_e'($urandom_range(0, 3));
          pace_left = $urandom_range(20, 200);
        end
        pace_left--;
        case (pace)
          PACE_FREE:   out_stall_i <= 1'b0;
          PACE_LIGHT:  out_stall_i <= ($urandom_range(0, 2) == 0);
          PACE_TOGGLE: out_stall_i <= ~out_stall_i;
          default:     out_stall_i <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // Stimulus
  initial begin
    logic [4:0] md;
    logic [5:0] fw;
    logic [6:0] cap;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero, 20-digit, most negative, decade edges
    send_value(mk(64'd0, 1'b0));
    send_value(mk(64'd0, 1'b1));
    send_value(mk('1, 1'b0));
    send_value(mk('1, 1'b1));
    send_value(mk(64'h8000_0000_0000_0000, 1'b1));
    send_value(mk(64'h8000_0000_0000_0000, 1'b0));
    send_value(mk(64'h7FFF_FFFF_FFFF_FFFF, 1'b1));
    send_value(mk(64'd9, 1'b1));
    send_value(mk(64'd10, 1'b0));
    send_value(mk(64'd9999999999999999999, 1'b0));
    send_value(mk(64'd10000000000000000000, 1'b0));
    send_value(mk(64'hFFFF_FFFF_FFFF_FFF6, 1'b1));
    send_value(mk(64'hFFFF_FFFF_FFFF_FFF6, 1'b0));
    drain();

    // zero fill past the digit cap, widest field, capacity past the limit
    set_config(5'd31, 6'd63, 7'd127, 1'b1);
    send_value(mk(64'd0, 1'b0));
    send_value(mk('1, 1'b1));
    send_value(mk(64'h8000_0000_0000_0000, 1'b1));
    drain();

    // padding cut short by a tiny capacity, then no room
    set_config(5'd0, 6'd10, 7'd2, 1'b0);
    send_value(mk(64'd5, 1'b0));
    send_value(mk(64'h8000_0000_0000_0000, 1'b0));
    drain();

    // exact fit against one past it with the sign
    set_config(5'd20, 6'd0, 7'd21, 1'b0);
    send_value(mk('1, 1'b0));
    send_value(mk(64'hFFFF_FFFF_FFFF_FFFB, 1'b1));
    drain();

    // zero capacity
    set_config(5'd0, 6'd0, 7'd0, 1'b0);
    send_value(mk(64'd0, 1'b0));
    drain();

    // random settings, each with a batch of random values
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 3))
        0: md = 5'd0;
        1: md = 5'd20;
        2: md = 5'd31;
        default: md = 5'($urandom_range(0, 31));
      endcase
      case ($urandom_range(0, 3))
        0: fw = 6'd0;
        1: fw = 6'd63;
        2: fw = 6'($urandom_range(0, 63));
        default: fw = 6'($urandom_range(0, 30));
      endcase
      case ($urandom_range(0, 7))
        0: cap = 7'($urandom_range(0, 1));
        1: cap = 7'($urandom_range(2, 21));
        2, 3: cap = 7'($urandom_range(22, 63));
        4: cap = 7'd64;
        5: cap = 7'd127;
        6: cap = 7'($urandom_range(65, 126));
        default: cap = 7'($urandom_range(0, 127));
      endcase
      set_config(md, fw, cap, 1'($urandom_range(0, 1)));
      // one long receiver hold-off while values keep coming
      if (ph == 1) long_hold_req = 1'b1;
      repeat (24) send_value(random_value());
      drain();
    end

    repeat (200) @(posedge clk_i);
    board.close_out();
    if (board.fail_count == 0)
      $display("[signed_decimal_ascii] OK");
    else
      $display("[signed_decimal_ascii] ERROR");
    $finish;
  end

  // Watchdog, well beyond the slowest correct run
  initial begin
    #2000000;
    $display("[signed_decimal_ascii] ERROR");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/sda_pkg.sv
rtl/core/sda_cell.sv
rtl/core/sda_chain.sv
rtl/core/signed_decimal_ascii.sv
tb/sv/signed_decimal_ascii_tb.sv
